// File: rtl/sgcc_pkg.sv
// sgcc_pkg: shared constants, types and helpers for the staggered grid to
// cell center averaging core. No dependencies.
`default_nettype none

package sgcc_pkg;

   localparam int MAX_DIM      = 64;
   localparam int SAMPLE_WIDTH = 32;
   localparam int DIM_WIDTH    = $clog2(MAX_DIM + 1);
   localparam int DELAY_DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_WIDTH   = $clog2(DELAY_DEPTH);
   localparam int INDEX_WIDTH  = 18;
   localparam int AXIS_WIDTH   = 2;
   localparam int CSR_WIDTH    = 2;
   localparam int GRID_RESET   = 16;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [DIM_WIDTH-1:0]           dim_type;
   typedef logic [ADDR_WIDTH-1:0]          addr_type;
   typedef logic [INDEX_WIDTH-1:0]         index_type;

   typedef enum logic [AXIS_WIDTH-1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef enum logic [CSR_WIDTH-1:0] {
      CSR_GRID_X = 2'd0,
      CSR_GRID_Y = 2'd1,
      CSR_GRID_Z = 2'd2
   } csr_index_type;

   // zero held as one, anything above the maximum held as the maximum
   function automatic dim_type clamp_dim(input dim_type v);
      dim_type r;
      if (v == '0) begin
         r = dim_type'(1);
      end else if (v > dim_type'(MAX_DIM)) begin
         r = dim_type'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

   // floor of the mean of two signed samples, no overflow
   function automatic sample_type floor_mean(input sample_type a, input sample_type b);
      logic signed [SAMPLE_WIDTH:0] sum;
      sum = {a[SAMPLE_WIDTH-1], a} + {b[SAMPLE_WIDTH-1], b};
      return sample_type'(sum[SAMPLE_WIDTH:1]);
   endfunction

endpackage

`default_nettype wire

// File: rtl/sgcc_if.sv
// sgcc_req_if / sgcc_rsp_if: valid/ready channels of the averaging core.
// Depends on sgcc_pkg.
`default_nettype none

interface sgcc_req_if;
   import sgcc_pkg::*;

   logic       valid;
   logic       ready;
   sample_type face_sample;

   modport source (output valid, output face_sample, input ready);
   modport sink   (input valid, input face_sample, output ready);
endinterface

interface sgcc_rsp_if;
   import sgcc_pkg::*;

   logic       valid;
   logic       ready;
   sample_type cell_average;
   axis_type   axis;
   index_type  cell_index;
   logic       last_of_field;

   modport source (output valid, output cell_average, output axis, output cell_index,
                   output last_of_field, input ready);
   modport sink   (input valid, input cell_average, input axis, input cell_index,
                   input last_of_field, output ready);
endinterface

`default_nettype wire

// File: rtl/staggered_grid_to_cell_center_core.sv
// staggered_grid_to_cell_center_core: top level of the MAC grid face to cell
// center averaging core. Depends on sgcc_pkg and the channel interfaces.
//
// Face samples stream in as x faces, then y faces, then z faces, each region
// x-fastest; every face except the first along the component axis yields the
// floor mean of itself and its neighbor face, tagged with axis, linear cell
// index and a last flag on the final z result. One beat is taken per cycle,
// with one read and one write of the delay memory per y or z beat; the
// input stalls only while results back up in the output register and the
// stage behind it. A result is registered in stage one and then in the output
// register. The row and plane neighbors come from a 4096 x 32 delay memory
// read and written at the same address in the accept cycle, so no
// forwarding is needed. A write to a grid register clamps the dimension to
// 1..64 and restarts the stream at the first x face; the delay memory needs
// no clearing since each entry is written before it is read.
`default_nettype none

module staggered_grid_to_cell_center_core (
   input  wire                         clock,
   input  wire                         reset,
   sgcc_req_if.sink                    req_chan,
   sgcc_rsp_if.source                  rsp_chan,
   input  wire                         csr_write,
   input  wire [sgcc_pkg::CSR_WIDTH-1:0] csr_index,
   input  wire [sgcc_pkg::DIM_WIDTH-1:0] csr_wdata
);

   import sgcc_pkg::*;

   dim_type    grid_x_ff, grid_y_ff, grid_z_ff;
   dim_type    pos_i_ff, pos_j_ff, pos_k_ff;
   dim_type    pos_i_in, pos_j_in, pos_k_in;
   axis_type   axis_ff, axis_in;
   addr_type   row_base_ff, row_base_in;
   index_type  cell_cnt_ff, cell_cnt_in;
   sample_type prev_ff;

   logic       s1_valid_ff, s1_emit_ff, s1_use_mem_ff, s1_last_ff;
   sample_type s1_sample_ff, s1_prev_ff, rd_ff;
   axis_type   s1_axis_ff;
   index_type  s1_index_ff;

   logic       rsp_valid_ff;
   sample_type rsp_average_ff;
   axis_type   rsp_axis_ff;
   index_type  rsp_index_ff;
   logic       rsp_last_ff;

   sample_type delay_mem [DELAY_DEPTH];

   logic          accept, s1_advance, emit, last, restart;
   logic [DIM_WIDTH:0] ext_i, ext_j, ext_k;
   logic          end_i, end_j, end_k;
   addr_type      addr;
   dim_type       csr_value;

   assign csr_value = clamp_dim(csr_wdata);
   assign restart   = csr_write && (csr_index == CSR_GRID_X || csr_index == CSR_GRID_Y
                                    || csr_index == CSR_GRID_Z);

   assign s1_advance     = !s1_emit_ff || !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      ext_i = {1'b0, grid_x_ff};
      ext_j = {1'b0, grid_y_ff};
      ext_k = {1'b0, grid_z_ff};
      emit  = 1'b0;
      last  = 1'b0;
      addr  = addr_type'(pos_i_ff);
      case (axis_ff)
         AXIS_X: begin
            ext_i = {1'b0, grid_x_ff} + 1'b1;
            emit  = (pos_i_ff != '0);
         end
         AXIS_Y: begin
            ext_j = {1'b0, grid_y_ff} + 1'b1;
            emit  = (pos_j_ff != '0);
         end
         AXIS_Z: begin
            ext_k = {1'b0, grid_z_ff} + 1'b1;
            emit  = (pos_k_ff != '0);
            addr  = row_base_ff + addr_type'(pos_i_ff);
            last  = (pos_k_ff != '0)
                    && ({1'b0, pos_i_ff} + 1'b1 == {1'b0, grid_x_ff})
                    && ({1'b0, pos_j_ff} + 1'b1 == {1'b0, grid_y_ff})
                    && (pos_k_ff == grid_z_ff);
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   assign end_i = ({1'b0, pos_i_ff} + 1'b1 == ext_i);
   assign end_j = ({1'b0, pos_j_ff} + 1'b1 == ext_j);
   assign end_k = ({1'b0, pos_k_ff} + 1'b1 == ext_k);

   // position walk and running cell index
   always_comb begin
      pos_i_in    = pos_i_ff;
      pos_j_in    = pos_j_ff;
      pos_k_in    = pos_k_ff;
      axis_in     = axis_ff;
      row_base_in = row_base_ff;
      cell_cnt_in = cell_cnt_ff;
      if (restart) begin
         pos_i_in    = '0;
         pos_j_in    = '0;
         pos_k_in    = '0;
         axis_in     = AXIS_X;
         row_base_in = '0;
         cell_cnt_in = '0;
      end else if (accept) begin
         if (emit) begin
            cell_cnt_in = cell_cnt_ff + 1'b1;
         end
         pos_i_in = pos_i_ff + 1'b1;
         if (end_i) begin
            pos_i_in    = '0;
            pos_j_in    = pos_j_ff + 1'b1;
            row_base_in = row_base_ff + addr_type'(grid_x_ff);
            if (end_j) begin
               pos_j_in    = '0;
               row_base_in = '0;
               pos_k_in    = pos_k_ff + 1'b1;
               if (end_k) begin
                  pos_k_in    = '0;
                  cell_cnt_in = '0;
                  case (axis_ff)
                     AXIS_X:  axis_in = AXIS_Y;
                     AXIS_Y:  axis_in = AXIS_Z;
                     default: axis_in = AXIS_X;
                  endcase
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_x_ff    <= dim_type'(GRID_RESET);
         grid_y_ff    <= dim_type'(GRID_RESET);
         grid_z_ff    <= dim_type'(GRID_RESET);
         pos_i_ff     <= '0;
         pos_j_ff     <= '0;
         pos_k_ff     <= '0;
         axis_ff      <= AXIS_X;
         row_base_ff  <= '0;
         cell_cnt_ff  <= '0;
         prev_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         s1_emit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_GRID_X: grid_x_ff <= csr_value;
               CSR_GRID_Y: grid_y_ff <= csr_value;
               CSR_GRID_Z: grid_z_ff <= csr_value;
               default:    grid_x_ff <= grid_x_ff;
            endcase
         end
         pos_i_ff    <= pos_i_in;
         pos_j_ff    <= pos_j_in;
         pos_k_ff    <= pos_k_in;
         axis_ff     <= axis_in;
         row_base_ff <= row_base_in;
         cell_cnt_ff <= cell_cnt_in;
         if (accept) begin
            prev_ff <= req_chan.face_sample;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
            s1_emit_ff  <= emit;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
            s1_emit_ff  <= 1'b0;
         end
         if (s1_valid_ff && s1_emit_ff && s1_advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // stage one payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff  <= req_chan.face_sample;
         s1_prev_ff    <= prev_ff;
         s1_use_mem_ff <= (axis_ff != AXIS_X);
         s1_axis_ff    <= axis_ff;
         s1_index_ff   <= cell_cnt_ff;
         s1_last_ff    <= last;
      end
   end

   // delay memory, read-first at the shared address
   always_ff @(posedge clock) begin
      if (accept && axis_ff != AXIS_X) begin
         rd_ff           <= delay_mem[addr];
         delay_mem[addr] <= req_chan.face_sample;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_emit_ff && s1_advance) begin
         rsp_average_ff <= floor_mean(s1_use_mem_ff ? rd_ff : s1_prev_ff, s1_sample_ff);
         rsp_axis_ff    <= s1_axis_ff;
         rsp_index_ff   <= s1_index_ff;
         rsp_last_ff    <= s1_last_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.cell_average  = rsp_average_ff;
   assign rsp_chan.axis          = rsp_axis_ff;
   assign rsp_chan.cell_index    = rsp_index_ff;
   assign rsp_chan.last_of_field = rsp_last_ff;

endmodule

`default_nettype wire
